[hw/rtl/idf_pkg.sv]
package idf_pkg;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_FILTER_ENABLE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TCP_ENABLE    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_APP_UID       = 2'd2;

    // Field widths.
    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned IDENT_W = 16;
    localparam int unsigned UID_W   = 32;
    localparam int unsigned CFG_W   = 32;
    localparam int unsigned IN_W    = ADDR_W + IDENT_W + UID_W;
    localparam int unsigned OUT_W   = 8;

    // Request to the shared compare unit.
    typedef struct packed {
        logic [ADDR_W-1:0] key;
        logic [ADDR_W-1:0] data;
        logic              wide;
    } cmp_req_t;

endpackage

[hw/rtl/idf_cmp_unit.sv]
// Shared equality unit: compares a full address, or only the low
// identification bits when a ring entry is checked.
module idf_cmp_unit (
    input  idf_pkg::cmp_req_t req,
    output logic              hit
);

    logic [idf_pkg::ADDR_W-1:0] mask;

    // Narrow compares look at the identification bits only.
    assign mask = req.wide ? {idf_pkg::ADDR_W{1'b1}}
                           : {{(idf_pkg::ADDR_W-idf_pkg::IDENT_W){1'b0}},
                              {idf_pkg::IDENT_W{1'b1}}};
    assign hit  = ((req.key ^ req.data) & mask) == '0;

endmodule

[hw/rtl/idf_store.sv]
// Connection table and identification rings, one write and one read port
// each, read data registered.
module idf_store #(
    parameter int unsigned CONNECTIONS = 16,
    parameter int unsigned SW          = 4,
    parameter int unsigned PW          = 7
) (
    input  logic                        aclk,
    input  logic                        conn_we,
    input  logic [SW-1:0]               conn_waddr,
    input  logic [idf_pkg::ADDR_W-1:0]  conn_wsource,
    input  logic                        conn_wfull,
    input  logic [PW-1:0]               conn_wpos,
    input  logic [SW-1:0]               conn_raddr,
    output logic [idf_pkg::ADDR_W-1:0]  conn_rsource,
    output logic                        conn_rfull,
    output logic [PW-1:0]               conn_rpos,
    input  logic                        ring_we,
    input  logic [SW+PW-1:0]            ring_waddr,
    input  logic [idf_pkg::IDENT_W-1:0] ring_wdata,
    input  logic [SW+PW-1:0]            ring_raddr,
    output logic [idf_pkg::IDENT_W-1:0] ring_rdata
);

    localparam int unsigned CONN_W     = idf_pkg::ADDR_W + 1 + PW;
    localparam int unsigned RING_DEPTH = 1 << (SW + PW);

    logic [CONN_W-1:0]           conn_mem [CONNECTIONS];
    logic [idf_pkg::IDENT_W-1:0] ring_mem [RING_DEPTH];
    logic [CONN_W-1:0]           conn_rd_reg;
    logic [idf_pkg::IDENT_W-1:0] ring_rd_reg;

    // Connection table: source address, ring full flag, ring write position.
    always_ff @(posedge aclk) begin
        if (conn_we) begin
            conn_mem[conn_waddr] <= {conn_wsource, conn_wfull, conn_wpos};
        end
        conn_rd_reg <= conn_mem[conn_raddr];
    end

    // Identification rings, one row per connection.
    always_ff @(posedge aclk) begin
        if (ring_we) begin
            ring_mem[ring_waddr] <= ring_wdata;
        end
        ring_rd_reg <= ring_mem[ring_raddr];
    end

    assign conn_rsource = conn_rd_reg[CONN_W-1 -: idf_pkg::ADDR_W];
    assign conn_rfull   = conn_rd_reg[PW];
    assign conn_rpos    = conn_rd_reg[PW-1:0];
    assign ring_rdata   = ring_rd_reg;

endmodule

[hw/rtl/ip_id_duplicate_filter.sv]
// IP identification duplicate filter.
// The input stream carries one packet header per transfer: s_tdata holds the
// source address, IP identification and socket user id, s_tuser flags TCP.
// The result stream returns one transfer per packet: drop and checked.
// The configuration port writes filter_enable, tcp_enable and app_uid; the user
// must write it only while the block is idle, which the block does not enforce.
// A packet that is not filtered goes straight to the result. A filtered packet
// walks the connection table one slot a cycle and, on a hit, the connection's
// ring one entry a cycle, every compare going through the one shared compare
// unit and the registered memory read ports.
// s_tready is high only while the sequencer is idle. The result waits in an
// output register; a stalled receiver holds it there while the next packet is
// taken, and the sequencer waits at its end until that register is free.
// Reset clears the configuration, the connection valid bits, the slot
// pointer and the counters; no clearing pass is needed, rings being tracked
// by a per-connection write position and full flag.
module ip_id_duplicate_filter #(
    parameter int unsigned CONNECTIONS  = 16,
    parameter int unsigned IDS_PER_CONN = 128
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // source_address [31:0], ip_ident [47:32], socket_uid [79:48]
    input  logic [idf_pkg::IN_W-1:0]          s_tdata,
    // is_tcp [0]
    input  logic                              s_tuser,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // drop [0], checked [1], zero fill [7:2]
    output logic [idf_pkg::OUT_W-1:0]         m_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_wr_en,
    input  logic [idf_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [idf_pkg::CFG_W-1:0]         cfg_wdata
);

    localparam int unsigned SW = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1;
    localparam int unsigned PW = (IDS_PER_CONN > 1) ? $clog2(IDS_PER_CONN) : 1;
    localparam logic [SW-1:0] LAST_SLOT = SW'(CONNECTIONS - 1);
    localparam logic [PW-1:0] LAST_POS  = PW'(IDS_PER_CONN - 1);

    typedef enum logic [2:0] {
        ST_IDLE, ST_CONN_SCAN, ST_RING_SCAN, ST_ALLOC, ST_WRITE, ST_DONE
    } state_t;

    state_t                      state_reg, state_next;
    logic                        filter_en_reg, filter_en_next;
    logic                        tcp_en_reg, tcp_en_next;
    logic [idf_pkg::UID_W-1:0]   app_uid_reg, app_uid_next;
    logic [idf_pkg::ADDR_W-1:0]  src_reg, src_next;
    logic [idf_pkg::IDENT_W-1:0] ident_reg, ident_next;
    logic [SW-1:0]               cscan_reg, cscan_next;
    logic [SW-1:0]               cchk_reg, cchk_next;
    logic                        clive_reg, clive_next;
    logic [PW-1:0]               rscan_reg, rscan_next;
    logic [PW-1:0]               rchk_reg, rchk_next;
    logic                        rlive_reg, rlive_next;
    logic [PW-1:0]               rlast_reg, rlast_next;
    logic [SW-1:0]               slot_reg, slot_next;
    logic [PW-1:0]               wpos_reg, wpos_next;
    logic                        full_reg, full_next;
    logic                        res_drop_reg, res_drop_next;
    logic                        res_checked_reg, res_checked_next;
    logic [SW-1:0]               next_slot_reg, next_slot_next;
    logic [CONNECTIONS-1:0]      conn_valid_reg, conn_valid_next;
    logic                        m_tvalid_reg, m_tvalid_next;
    logic [idf_pkg::OUT_W-1:0]   m_tdata_reg, m_tdata_next;
    logic [31:0]                 drop_count_reg, drop_count_next;
    logic [31:0]                 pass_count_reg, pass_count_next;

    logic                        in_fire;
    logic                        pkt_checked;
    logic [idf_pkg::ADDR_W-1:0]  in_source;
    logic [idf_pkg::IDENT_W-1:0] in_ident;
    logic [idf_pkg::UID_W-1:0]   in_uid;
    logic [idf_pkg::ADDR_W-1:0]  conn_rsource;
    logic                        conn_rfull;
    logic [PW-1:0]               conn_rpos;
    logic [idf_pkg::IDENT_W-1:0] ring_rdata;
    logic                        conn_we, ring_we;
    logic                        wr_last;
    idf_pkg::cmp_req_t           cmp_req;
    logic                        cmp_hit;

    // Input field unpacking and the filter condition.
    assign in_source = s_tdata[idf_pkg::ADDR_W-1:0];
    assign in_ident  = s_tdata[idf_pkg::ADDR_W +: idf_pkg::IDENT_W];
    assign in_uid    = s_tdata[idf_pkg::ADDR_W+idf_pkg::IDENT_W +: idf_pkg::UID_W];
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign pkt_checked = filter_en_reg && (!s_tuser || tcp_en_reg)
                         && (app_uid_reg != '0) && (in_uid == app_uid_reg);

    // The shared compare unit serves both the table walk and the ring walk.
    always_comb begin
        if (state_reg == ST_RING_SCAN) begin
            cmp_req.key  = {{(idf_pkg::ADDR_W-idf_pkg::IDENT_W){1'b0}}, ident_reg};
            cmp_req.data = {{(idf_pkg::ADDR_W-idf_pkg::IDENT_W){1'b0}}, ring_rdata};
            cmp_req.wide = 1'b0;
        end else begin
            cmp_req.key  = src_reg;
            cmp_req.data = conn_rsource;
            cmp_req.wide = 1'b1;
        end
    end

    idf_cmp_unit u_cmp (
        .req (cmp_req),
        .hit (cmp_hit)
    );

    // Writes of the new identification and the updated ring position.
    assign conn_we = (state_reg == ST_WRITE);
    assign ring_we = (state_reg == ST_WRITE);
    assign wr_last = (wpos_reg == LAST_POS);

    idf_store #(
        .CONNECTIONS (CONNECTIONS),
        .SW          (SW),
        .PW          (PW)
    ) u_store (
        .aclk         (aclk),
        .conn_we      (conn_we),
        .conn_waddr   (slot_reg),
        .conn_wsource (src_reg),
        .conn_wfull   (full_reg || wr_last),
        .conn_wpos    (wr_last ? '0 : PW'(wpos_reg + PW'(1))),
        .conn_raddr   (cscan_reg),
        .conn_rsource (conn_rsource),
        .conn_rfull   (conn_rfull),
        .conn_rpos    (conn_rpos),
        .ring_we      (ring_we),
        .ring_waddr   ({slot_reg, wpos_reg}),
        .ring_wdata   (ident_reg),
        .ring_raddr   ({slot_reg, rscan_reg}),
        .ring_rdata   (ring_rdata)
    );

    // Sequencer and output register next state.
    always_comb begin
        state_next       = state_reg;
        filter_en_next   = filter_en_reg;
        tcp_en_next      = tcp_en_reg;
        app_uid_next     = app_uid_reg;
        src_next         = src_reg;
        ident_next       = ident_reg;
        cscan_next       = cscan_reg;
        cchk_next        = cchk_reg;
        clive_next       = clive_reg;
        rscan_next       = rscan_reg;
        rchk_next        = rchk_reg;
        rlive_next       = rlive_reg;
        rlast_next       = rlast_reg;
        slot_next        = slot_reg;
        wpos_next        = wpos_reg;
        full_next        = full_reg;
        res_drop_next    = res_drop_reg;
        res_checked_next = res_checked_reg;
        next_slot_next   = next_slot_reg;
        conn_valid_next  = conn_valid_reg;
        m_tvalid_next    = m_tvalid_reg;
        m_tdata_next     = m_tdata_reg;
        drop_count_next  = drop_count_reg;
        pass_count_next  = pass_count_reg;

        // Configuration writes; indexes past the list are ignored.
        if (cfg_wr_en) begin
            case (cfg_index)
                idf_pkg::REG_FILTER_ENABLE: filter_en_next = cfg_wdata[0];
                idf_pkg::REG_TCP_ENABLE:    tcp_en_next    = cfg_wdata[0];
                idf_pkg::REG_APP_UID:       app_uid_next   = cfg_wdata;
                default: ;
            endcase
        end

        // The receiver took the pending result.
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    src_next   = in_source;
                    ident_next = in_ident;
                    cscan_next = '0;
                    clive_next = 1'b0;
                    if (pkt_checked) begin
                        state_next = ST_CONN_SCAN;
                    end else begin
                        res_drop_next    = 1'b0;
                        res_checked_next = 1'b0;
                        state_next       = ST_DONE;
                    end
                end
            end
            ST_CONN_SCAN: begin
                // Read data is registered; cchk_reg holds the slot that it belongs to.
                if (clive_reg && conn_valid_reg[cchk_reg] && cmp_hit) begin
                    slot_next  = cchk_reg;
                    wpos_next  = conn_rpos;
                    full_next  = conn_rfull;
                    rlast_next = conn_rfull ? LAST_POS : PW'(conn_rpos - PW'(1));
                    rscan_next = '0;
                    rlive_next = 1'b0;
                    state_next = ST_RING_SCAN;
                end else if (clive_reg && (cchk_reg == LAST_SLOT)) begin
                    state_next = ST_ALLOC;
                end else begin
                    cchk_next  = cscan_reg;
                    clive_next = 1'b1;
                    if (cscan_reg != LAST_SLOT) begin
                        cscan_next = SW'(cscan_reg + SW'(1));
                    end
                end
            end
            ST_RING_SCAN: begin
                // Only entries below the write position, or all once full.
                if (rlive_reg && cmp_hit) begin
                    res_drop_next    = 1'b1;
                    res_checked_next = 1'b1;
                    state_next       = ST_DONE;
                end else if (rlive_reg && (rchk_reg == rlast_reg)) begin
                    state_next = ST_WRITE;
                end else begin
                    rchk_next  = rscan_reg;
                    rlive_next = 1'b1;
                    if (rscan_reg != rlast_reg) begin
                        rscan_next = PW'(rscan_reg + PW'(1));
                    end
                end
            end
            ST_ALLOC: begin
                // Take over the round-robin slot with an empty ring.
                slot_next                      = next_slot_reg;
                wpos_next                      = '0;
                full_next                      = 1'b0;
                conn_valid_next[next_slot_reg] = 1'b1;
                next_slot_next = (next_slot_reg == LAST_SLOT) ? '0
                                 : SW'(next_slot_reg + SW'(1));
                state_next     = ST_WRITE;
            end
            ST_WRITE: begin
                res_drop_next    = 1'b0;
                res_checked_next = 1'b1;
                state_next       = ST_DONE;
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{(idf_pkg::OUT_W-2){1'b0}},
                                     res_checked_reg, res_drop_reg};
                    if (res_drop_reg) begin
                        drop_count_next = drop_count_reg + 32'd1;
                    end else if (res_checked_reg) begin
                        pass_count_next = pass_count_reg + 32'd1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            filter_en_reg  <= 1'b0;
            tcp_en_reg     <= 1'b0;
            app_uid_reg    <= '0;
            next_slot_reg  <= '0;
            conn_valid_reg <= '0;
            m_tvalid_reg   <= 1'b0;
            drop_count_reg <= '0;
            pass_count_reg <= '0;
            clive_reg      <= 1'b0;
            rlive_reg      <= 1'b0;
        end else begin
            state_reg      <= state_next;
            filter_en_reg  <= filter_en_next;
            tcp_en_reg     <= tcp_en_next;
            app_uid_reg    <= app_uid_next;
            next_slot_reg  <= next_slot_next;
            conn_valid_reg <= conn_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
            drop_count_reg <= drop_count_next;
            pass_count_reg <= pass_count_next;
            clive_reg      <= clive_next;
            rlive_reg      <= rlive_next;
        end
        src_reg         <= src_next;
        ident_reg       <= ident_next;
        cscan_reg       <= cscan_next;
        cchk_reg        <= cchk_next;
        rscan_reg       <= rscan_next;
        rchk_reg        <= rchk_next;
        rlast_reg       <= rlast_next;
        slot_reg        <= slot_next;
        wpos_reg        <= wpos_next;
        full_reg        <= full_next;
        res_drop_reg    <= res_drop_next;
        res_checked_reg <= res_checked_next;
        m_tdata_reg     <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // A dropped packet always went through the table.
    a_drop_checked: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!m_tdata[0] || m_tdata[1]))
        else $error("drop reported for an unchecked packet");

    // A transfer on the input closes the input until the packet is done.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> !s_tready)
        else $error("input accepted while a packet is in progress");

    // The ring walk only runs on a valid connection.
    a_ring_slot_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RING_SCAN) |-> conn_valid_reg[slot_reg])
        else $error("ring walk on an unused connection");

    // The ring walk never passes its last filled entry.
    a_ring_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RING_SCAN) |-> (rscan_reg <= rlast_reg))
        else $error("ring walk beyond the filled entries");

    // Counters move only when a result is loaded.
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (drop_count_reg != $past(drop_count_reg)
         || pass_count_reg != $past(pass_count_reg)) |-> $past(state_reg == ST_DONE))
        else $error("counter changed outside the result load");

endmodule

[test/tb_top.sv]
module tb_top;

    localparam int unsigned CONNS      = 16;
    localparam int unsigned IDS        = 128;
    localparam int unsigned POOL_SIZE  = 32;
    localparam int unsigned IDLE_PCT   = 29;
    localparam int unsigned HOLD_LEN   = 300;
    localparam int unsigned DRAIN_LEN  = 200;
    localparam int unsigned CYCLE_CAP  = 1000000;
    // Index past the end of the register list; writes to it must be ignored.
    localparam logic [idf_pkg::CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic drop;
        logic checked;
    } verdict_t;

    logic                            aclk;
    logic                            aresetn   = 1'b0;
    logic [idf_pkg::IN_W-1:0]        s_tdata   = '0;
    logic                            s_tuser   = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [idf_pkg::OUT_W-1:0]       m_tdata;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [idf_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [idf_pkg::CFG_W-1:0]       cfg_wdata = '0;

    // Shadow configuration, updated on every write to a listed register.
    logic        filt_on;
    logic        tcp_on;
    logic [31:0] owner_uid;

    // Shadow of the connection table and the per-connection ID rings.
    logic [31:0] conn_src  [CONNS];
    logic        conn_live [CONNS];
    logic [15:0] ring_id   [CONNS][IDS];
    logic        ring_live [CONNS][IDS];
    int          ring_pos  [CONNS];
    int          alloc_slot;

    verdict_t    pending_verdicts[$];
    logic [31:0] src_pool[POOL_SIZE];
    int          mismatch_count = 0;
    int          cycle_count    = 0;
    bit          no_idle        = 1'b0;
    bit          hold_req       = 1'b0;

    ip_id_duplicate_filter #(
        .CONNECTIONS (CONNS),
        .IDS_PER_CONN(IDS)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    // Free-running clock.
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Watchdog: a run that reaches the cycle cap has hung.
    initial begin
        while (cycle_count < CYCLE_CAP) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    // Decide drop/checked for one packet and update the shadow table.
    function automatic verdict_t judge_packet(input logic [31:0] src, input logic [15:0] ident,
                                              input logic tcp, input logic [31:0] uid);
        verdict_t v;
        int       slot;
        bit       hit;
        bit       seen;
        v    = '0;
        slot = 0;
        hit  = 1'b0;
        seen = 1'b0;
        if (!filt_on || (tcp && !tcp_on) || owner_uid == 32'd0 || uid != owner_uid) begin
            return v;
        end
        v.checked = 1'b1;
        // First live slot with a matching source wins.
        for (int k = 0; k < CONNS; k++) begin
            if (!hit && conn_live[k] && conn_src[k] == src) begin
                slot = k;
                hit  = 1'b1;
            end
        end
        if (hit) begin
            for (int k = 0; k < IDS; k++) begin
                if (ring_live[slot][k] && ring_id[slot][k] == ident) begin
                    seen = 1'b1;
                end
            end
            if (seen) begin
                v.drop = 1'b1;
            end else begin
                ring_id[slot][ring_pos[slot]]   = ident;
                ring_live[slot][ring_pos[slot]] = 1'b1;
                ring_pos[slot] = (ring_pos[slot] + 1) % IDS;
            end
        end else begin
            // Miss: take over the round-robin slot and start its ring afresh.
            slot = alloc_slot;
            conn_src[slot]  = src;
            conn_live[slot] = 1'b1;
            for (int k = 0; k < IDS; k++) begin
                ring_live[slot][k] = 1'b0;
            end
            ring_id[slot][0]   = ident;
            ring_live[slot][0] = 1'b1;
            ring_pos[slot]     = 1 % IDS;
            alloc_slot = (slot + 1) % CONNS;
        end
        return v;
    endfunction

    // Offer one packet, wait for its transfer and record the expected verdict.
    task automatic send_packet(input logic [31:0] src, input logic [15:0] ident,
                               input logic tcp, input logic [31:0] uid);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {uid, ident, src};
        s_tuser  <= tcp;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        pending_verdicts.push_back(judge_packet(src, ident, tcp, uid));
    endtask

    // Stop offering and wait until every verdict has come back.
    task automatic settle_block();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_verdicts.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [idf_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [idf_pkg::CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            idf_pkg::REG_FILTER_ENABLE: filt_on   = val[0];
            idf_pkg::REG_TCP_ENABLE:    tcp_on    = val[0];
            idf_pkg::REG_APP_UID:       owner_uid = val[31:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // Receiver: random stalls, a calm stretch, and one long hold-off on request.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_LEN - 1) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Compare each result transfer with the oldest expected verdict.
    initial begin
        verdict_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                if (pending_verdicts.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("%0t: result transfer with nothing expected, drop %0b checked %0b",
                                 $realtime, m_tdata[0], m_tdata[1]);
                    end
                end else begin
                    want = pending_verdicts.pop_front();
                    if (m_tdata[0] !== want.drop || m_tdata[1] !== want.checked) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("%0t: drop exp %0b got %0b, checked exp %0b got %0b",
                                     $realtime, want.drop, m_tdata[0], want.checked, m_tdata[1]);
                        end
                    end
                end
            end
        end
    end

    // With filtering off after reset, nothing is checked.
    task automatic test_unfiltered_after_reset();
        send_packet(32'h0000_0000, 16'h0000, 1'b0, 32'h0000_0000);
        send_packet(32'hFFFF_FFFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);
    endtask

    // A zero app_uid disables filtering even when enabled.
    task automatic test_zero_uid();
        settle_block();
        write_reg(idf_pkg::REG_FILTER_ENABLE, 32'd1);
        write_reg(idf_pkg::REG_TCP_ENABLE, 32'd0);
        write_reg(idf_pkg::REG_APP_UID, 32'd0);
        send_packet(32'h0000_0000, 16'h0000, 1'b0, 32'h0000_0000);
        send_packet(32'h1234_5678, 16'h0001, 1'b0, 32'h0000_0000);
    endtask

    // Hits, misses, duplicates, unused slots and the bypass conditions.
    task automatic test_table_basics();
        settle_block();
        write_reg(idf_pkg::REG_APP_UID, 32'hFFFF_FFFF);
        write_reg(REG_SPARE, 32'hFFFF_FFFF);
        // A zero source must not match an unused slot.
        send_packet(32'h0000_0000, 16'h0000, 1'b0, 32'hFFFF_FFFF);
        send_packet(32'h0000_0000, 16'h0000, 1'b0, 32'hFFFF_FFFF);
        send_packet(32'h0000_0000, 16'hFFFF, 1'b0, 32'hFFFF_FFFF);
        send_packet(32'h0000_0000, 16'hFFFF, 1'b0, 32'hFFFF_FFFF);
        send_packet(32'hFFFF_FFFF, 16'h0000, 1'b0, 32'hFFFF_FFFF);
        // TCP bypasses while TCP filtering is off; a foreign uid bypasses.
        send_packet(32'hFFFF_FFFF, 16'h0000, 1'b1, 32'hFFFF_FFFF);
        send_packet(32'h0000_0000, 16'h0000, 1'b0, 32'hFFFF_FFFE);
        send_packet(32'h0000_0000, 16'h0000, 1'b0, 32'hFFFF_FFFF);
    endtask

    // TCP packets are checked once TCP filtering is on; disabling passes all.
    task automatic test_tcp_filter();
        settle_block();
        write_reg(idf_pkg::REG_TCP_ENABLE, 32'd1);
        send_packet(32'hFFFF_FFFF, 16'h0000, 1'b1, 32'hFFFF_FFFF);
        send_packet(32'hFFFF_FFFF, 16'h1234, 1'b1, 32'hFFFF_FFFF);
        send_packet(32'hFFFF_FFFF, 16'h1234, 1'b0, 32'hFFFF_FFFF);
        settle_block();
        write_reg(idf_pkg::REG_FILTER_ENABLE, 32'd0);
        send_packet(32'hFFFF_FFFF, 16'h1234, 1'b0, 32'hFFFF_FFFF);
        send_packet(32'h0000_0000, 16'h0000, 1'b1, 32'hFFFF_FFFF);
    endtask

    // The receiver holds off while packets keep coming, so the input stalls.
    task automatic test_input_hold_off();
        settle_block();
        write_reg(idf_pkg::REG_FILTER_ENABLE, 32'd1);
        no_idle  = 1'b1;
        hold_req = 1'b1;
        for (int i = 0; i < 10; i++) begin
            send_packet(src_pool[$urandom_range(3)], 16'(16'h0100 + $urandom_range(3)),
                        1'($urandom_range(1)), 32'hFFFF_FFFF);
        end
        no_idle = 1'b0;
    endtask

    // Random traffic over a window of sources and a band of IDs, with some noise.
    task automatic run_random(input int count, input int n_src, input int id_span,
                              input int noise_pct);
        int          start;
        logic [15:0] id_base;
        start   = $urandom_range(POOL_SIZE - 1);
        id_base = 16'($urandom);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < noise_pct) begin
                send_packet($urandom, 16'($urandom), 1'($urandom_range(1)), $urandom);
            end else begin
                send_packet(src_pool[(start + $urandom_range(n_src - 1)) % POOL_SIZE],
                            16'(id_base + $urandom_range(id_span - 1)),
                            1'($urandom_range(1)), owner_uid);
            end
        end
    endtask

    // Several settings, one random phase each.
    task automatic test_random_traffic();
        // One connection and a wide ID band: the ring wraps around.
        settle_block();
        write_reg(idf_pkg::REG_TCP_ENABLE, 32'd1);
        write_reg(idf_pkg::REG_APP_UID, $urandom | 32'd1);
        run_random(200, 1, 512, 5);
        // More sources than slots: round-robin eviction, no idling at all.
        settle_block();
        write_reg(idf_pkg::REG_TCP_ENABLE, 32'd0);
        write_reg(idf_pkg::REG_APP_UID, 32'd1);
        no_idle = 1'b1;
        run_random(150, 24, 8, 10);
        no_idle = 1'b0;
        settle_block();
        write_reg(idf_pkg::REG_TCP_ENABLE, 32'd1);
        write_reg(idf_pkg::REG_APP_UID, $urandom | 32'd1);
        run_random(100, 4, 24, 10);
        settle_block();
        write_reg(idf_pkg::REG_FILTER_ENABLE, 32'd0);
        run_random(30, 4, 16, 20);
        settle_block();
        write_reg(idf_pkg::REG_FILTER_ENABLE, 32'd1);
        write_reg(idf_pkg::REG_APP_UID, $urandom | 32'd1);
        run_random(40, 32, 64, 50);
    endtask

    initial begin
        filt_on    = 1'b0;
        tcp_on     = 1'b0;
        owner_uid  = 32'd0;
        alloc_slot = 0;
        for (int c = 0; c < CONNS; c++) begin
            conn_src[c]  = 32'd0;
            conn_live[c] = 1'b0;
            ring_pos[c]  = 0;
            for (int k = 0; k < IDS; k++) begin
                ring_id[c][k]   = 16'd0;
                ring_live[c][k] = 1'b0;
            end
        end
        src_pool[0] = 32'h0000_0000;
        src_pool[1] = 32'hFFFF_FFFF;
        for (int p = 2; p < POOL_SIZE; p++) begin
            src_pool[p] = $urandom;
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_unfiltered_after_reset();
        test_zero_uid();
        test_table_basics();
        test_tcp_filter();
        test_input_hold_off();
        test_random_traffic();

        settle_block();
        repeat (DRAIN_LEN) @(posedge aclk);
        mismatch_count += pending_verdicts.size();
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
